FILE: src/mhqs_pkg.sv
// mhqs_pkg: shared widths, default sizes, request and status codes
package mhqs_pkg;

  localparam int NUM_HANDLES_DEF = 32;
  localparam int DEPTH_DEF       = 16;
  localparam int WORD_BITS_DEF   = 32;

  localparam int REQ_BITS    = 2;
  localparam int HANDLE_BITS = 5;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 3;
  localparam int COUNT_BITS  = 5;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_OPEN  = 2'd0,
    REQ_CLOSE = 2'd1,
    REQ_PUSH  = 2'd2,
    REQ_POP   = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 3'd0,
    ST_NOFREE = 3'd1,
    ST_BADH   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4,
    ST_NULL   = 3'd5
  } status_t;

endpackage

FILE: src/mhqs_req_if.sv
// mhqs_req_if: request channel, valid/ready with request payload
interface mhqs_req_if import mhqs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [REQ_BITS-1:0]    req_type;
  logic                   kind;
  logic [HANDLE_BITS-1:0] handle;
  logic [VALUE_BITS-1:0]  value;

  modport source (output valid, output req_type, output kind, output handle,
                  output value, input ready);
  modport sink   (input valid, input req_type, input kind, input handle,
                  input value, output ready);
endinterface

FILE: src/mhqs_res_if.sv
// mhqs_res_if: result channel, valid/ready with result payload
interface mhqs_res_if import mhqs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [HANDLE_BITS-1:0] handle_out;
  logic [VALUE_BITS-1:0]  value_out;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, output status, output handle_out,
                  output value_out, output count, input ready);
  modport sink   (input valid, input status, input handle_out,
                  input value_out, input count, output ready);
endinterface

FILE: src/mhqs_ram.sv
// mhqs_ram: generic single-port RAM with registered read
module mhqs_ram import mhqs_pkg::*; #(
  parameter int WIDTH       = WORD_BITS_DEF,
  parameter int DEPTH_WORDS = NUM_HANDLES_DEF * DEPTH_DEF
) (
  input  logic                           clk,
  input  logic [$clog2(DEPTH_WORDS)-1:0] addr,
  input  logic                           we,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           re,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: src/multi_handle_queue_stack.sv
// multi_handle_queue_stack: handle pool of FIFO queues and LIFO stacks on a shared RAM
//
//  channel | role | words carried                         | taken when
//  req     | sink | req_type, kind, handle, value          | req.valid && req.ready
//  res     | src  | status, handle_out, value_out, count   | res.valid && res.ready
//
//  one request a cycle unless res stalls; results pass the input and result registers
//  the rate is set by the single RAM port and the per-handle state update
//  synchronous reset closes every handle at once, no clearing pass over the RAM
//  a stalled result holds the whole pipe; req stays ready while the next slot is free
module multi_handle_queue_stack import mhqs_pkg::*; #(
  parameter int NUM_HANDLES = NUM_HANDLES_DEF,
  parameter int DEPTH       = DEPTH_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mhqs_req_if.sink   req,
  mhqs_res_if.source res
);

  localparam int HW  = $clog2(NUM_HANDLES);
  localparam int SW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int AW  = $clog2(NUM_HANDLES * DEPTH);
  localparam int SSW = SW + 1;
  localparam logic [SSW-1:0] DEPTH_S = SSW'(DEPTH);
  localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0]  DEPTH_A = AW'(DEPTH);

  function automatic logic [SW-1:0] wrap(input logic [SSW-1:0] s);
    if (s >= DEPTH_S) begin
      wrap = SW'(s - DEPTH_S);
    end else begin
      wrap = SW'(s);
    end
  endfunction

  // per-handle state
  logic [NUM_HANDLES-1:0] open_flags;
  logic [NUM_HANDLES-1:0] handle_kind;
  logic [SW-1:0]          oldest_index [NUM_HANDLES];
  logic [CW-1:0]          entry_count  [NUM_HANDLES];

  // input register
  logic                   s1_valid;
  req_type_t              s1_req;
  logic                   s1_kind;
  logic [HANDLE_BITS-1:0] s1_handle;
  logic [VALUE_BITS-1:0]  s1_value;

  // result register
  logic                   res_valid;
  status_t                r_status;
  logic [HANDLE_BITS-1:0] r_handle;
  logic [COUNT_BITS-1:0]  r_count;
  logic                   r_popped;

  logic advance;
  logic fire;
  logic take;

  assign advance   = !res_valid || res.ready;
  assign fire      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_req    <= req_type_t'(req.req_type);
      s1_kind   <= req.kind;
      s1_handle <= req.handle;
      s1_value  <= req.value;
    end
  end

  // lowest free handle
  logic          free_found;
  logic [HW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_HANDLES - 1; i >= 0; i--) begin
      if (!open_flags[i]) begin
        free_found = 1'b1;
        free_idx   = HW'(i);
      end
    end
  end

  logic [HW-1:0]        hidx;
  logic                 h_ok;
  logic [SW-1:0]        cur_old;
  logic [CW-1:0]        cur_cnt;
  logic                 cur_kind;
  logic [WORD_BITS-1:0] wval;

  assign hidx     = HW'(s1_handle);
  assign h_ok     = (32'(s1_handle) < NUM_HANDLES) && open_flags[hidx];
  assign cur_old  = oldest_index[hidx];
  assign cur_cnt  = entry_count[hidx];
  assign cur_kind = handle_kind[hidx];
  assign wval     = WORD_BITS'(s1_value);

  status_t                st;
  logic [HANDLE_BITS-1:0] hout;
  logic [CW-1:0]          new_cnt;
  logic [SW-1:0]          new_old;
  logic [SW-1:0]          slot;
  logic                   do_open;
  logic                   do_close;
  logic                   do_push;
  logic                   do_pop;

  always_comb begin
    st       = ST_OK;
    hout     = s1_handle;
    new_cnt  = '0;
    new_old  = cur_old;
    slot     = cur_old;
    do_open  = 1'b0;
    do_close = 1'b0;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    case (s1_req)
      REQ_OPEN: begin
        if (free_found) begin
          hout    = HANDLE_BITS'(free_idx);
          do_open = 1'b1;
        end else begin
          st   = ST_NOFREE;
          hout = '0;
        end
      end
      REQ_CLOSE: begin
        if (!h_ok) begin
          st = ST_BADH;
        end else begin
          do_close = 1'b1;
        end
      end
      REQ_PUSH: begin
        if (!h_ok) begin
          st = ST_BADH;
        end else if (!cur_kind && wval == '0) begin
          st      = ST_NULL;
          new_cnt = cur_cnt;
        end else if (cur_cnt == DEPTH_C) begin
          st      = ST_FULL;
          new_cnt = cur_cnt;
        end else begin
          slot    = wrap(SSW'(cur_old) + SSW'(cur_cnt));
          new_cnt = cur_cnt + CW'(1);
          do_push = 1'b1;
        end
      end
      REQ_POP: begin
        if (!h_ok) begin
          st = ST_BADH;
        end else if (cur_cnt == '0) begin
          st = ST_EMPTY;
        end else begin
          new_cnt = cur_cnt - CW'(1);
          do_pop  = 1'b1;
          if (!cur_kind) begin
            slot    = cur_old;
            new_old = wrap(SSW'(cur_old) + SSW'(1));
          end else begin
            slot = wrap(SSW'(cur_old) + SSW'(cur_cnt) - SSW'(1));
          end
        end
      end
      default: begin
        st = ST_BADH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flags  <= '0;
      handle_kind <= '0;
      for (int i = 0; i < NUM_HANDLES; i++) begin
        oldest_index[i] <= '0;
        entry_count[i]  <= '0;
      end
    end else if (fire) begin
      if (do_open) begin
        open_flags[free_idx]   <= 1'b1;
        handle_kind[free_idx]  <= s1_kind;
        oldest_index[free_idx] <= '0;
        entry_count[free_idx]  <= '0;
      end
      if (do_close) begin
        open_flags[hidx]   <= 1'b0;
        handle_kind[hidx]  <= 1'b0;
        oldest_index[hidx] <= '0;
        entry_count[hidx]  <= '0;
      end
      if (do_push || do_pop) begin
        oldest_index[hidx] <= new_old;
        entry_count[hidx]  <= new_cnt;
      end
    end
  end

  // entry store
  logic [AW-1:0]        ram_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;

  assign ram_addr = AW'(hidx) * DEPTH_A + AW'(slot);
  assign ram_we   = fire && do_push;
  assign ram_re   = fire && do_pop;

  mhqs_ram #(
    .WIDTH       (WORD_BITS),
    .DEPTH_WORDS (NUM_HANDLES * DEPTH)
  ) u_store (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (wval),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_status <= st;
      r_handle <= hout;
      r_count  <= COUNT_BITS'(new_cnt);
      r_popped <= do_pop;
    end
  end

  assign res.valid      = res_valid;
  assign res.status     = r_status;
  assign res.handle_out = r_handle;
  assign res.count      = r_count;
  assign res.value_out  = r_popped ? VALUE_BITS'(ram_rdata) : '0;

  a_one_ram_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> cur_cnt <= DEPTH_C)
    else $error("handle count beyond depth");

  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !open_flags[hidx] |-> cur_cnt == '0 && cur_old == '0)
    else $error("closed handle still holds entries");

  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && r_popped |-> r_status == ST_OK)
    else $error("word popped with a failing status");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && r_popped && !res.ready |=> $stable(ram_rdata))
    else $error("popped word changed under a stall");

endmodule
